FILE: rtl/core/vat_pkg.sv
// Shared sizes and derived widths for the virtual address translator.
package vat_pkg;

   localparam int TLB_ENTRIES = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_COUNT = 256;

   localparam int ADDR_W    = 16;
   localparam int OFFSET_W  = 8;
   localparam int RAW_PAGE_W = 8;
   localparam int COUNT_W   = 32;

   localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

endpackage

FILE: rtl/core/virtual_address_translator_top.sv
// Address translator: sequential TLB scan with page table fallback and FIFO refill.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------------------
//   req     | in        | req_valid, req_stall, req_logical_address
//   rsp     | out       | rsp_valid, rsp_stall, rsp_physical_address, rsp_tlb_hit,
//           |           | rsp_page_fault, rsp_hit_total, rsp_fault_total
//
// From acceptance, an item passes through ST_REDUCE, ST_SCAN and, on a miss, ST_LOOKUP to
// ST_FINISH, where the result register is loaded. ST_REDUCE subtracts PAGE_COUNT until the
// page is in range (no subtraction at 256 pages); the single tag comparator in ST_SCAN visits
// TLB entries in order up to the hit, or all TLB_ENTRIES on a miss. req_stall is high until the
// result is loaded. The result register frees the sequencer; a new result waits only while
// the previous one is still stalled. Synchronous reset clears the TLB and page table valid
// bits, the free frame pointer and both totals; no clearing pass is needed.
module virtual_address_translator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vat_pkg::ADDR_W-1:0]      req_logical_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vat_pkg::ADDR_W-1:0]      rsp_physical_address,
   output logic                            rsp_tlb_hit,
   output logic                            rsp_page_fault,
   output logic [vat_pkg::COUNT_W-1:0]     rsp_hit_total,
   output logic [vat_pkg::COUNT_W-1:0]     rsp_fault_total
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   localparam logic [vat_pkg::RAW_PAGE_W:0] PAGE_LIMIT =
      (vat_pkg::RAW_PAGE_W + 1)'(vat_pkg::PAGE_COUNT);
   localparam logic [vat_pkg::RAW_PAGE_W-1:0] PAGE_STEP =
      vat_pkg::RAW_PAGE_W'(vat_pkg::PAGE_COUNT);
   localparam logic [vat_pkg::TLB_IDX_W-1:0] TLB_LAST =
      vat_pkg::TLB_IDX_W'(vat_pkg::TLB_ENTRIES - 1);
   localparam logic [vat_pkg::FRAME_W-1:0] FRAME_LAST =
      vat_pkg::FRAME_W'(vat_pkg::FRAME_COUNT - 1);

   state_type                            state_ff;
   logic [vat_pkg::RAW_PAGE_W-1:0]       page_ff;
   logic [vat_pkg::OFFSET_W-1:0]         offset_ff;
   logic [vat_pkg::TLB_IDX_W-1:0]        scan_ff;
   logic [vat_pkg::FRAME_W-1:0]          frame_ff;
   logic                                 hit_ff;
   logic                                 fault_ff;
   logic [vat_pkg::FRAME_W-1:0]          next_free_ff;
   logic [vat_pkg::COUNT_W-1:0]          hit_count_ff;
   logic [vat_pkg::COUNT_W-1:0]          fault_count_ff;

   logic [vat_pkg::PAGE_W-1:0]           tlb_tag_ff   [vat_pkg::TLB_ENTRIES];
   logic [vat_pkg::FRAME_W-1:0]          tlb_frame_ff [vat_pkg::TLB_ENTRIES];
   logic [vat_pkg::TLB_ENTRIES-1:0]      tlb_valid_ff;
   logic [vat_pkg::PAGE_COUNT-1:0]       table_valid_ff;

   logic [vat_pkg::FRAME_W-1:0]          table_frame_ff [vat_pkg::PAGE_COUNT];
   logic [vat_pkg::FRAME_W-1:0]          table_rd_ff;

   logic                                 rsp_valid_ff;
   logic [vat_pkg::ADDR_W-1:0]           rsp_addr_ff;
   logic                                 rsp_hit_ff;
   logic                                 rsp_fault_ff;
   logic [vat_pkg::COUNT_W-1:0]          rsp_hit_total_ff;
   logic [vat_pkg::COUNT_W-1:0]          rsp_fault_total_ff;

   logic [vat_pkg::PAGE_W-1:0]           page_idx;
   logic                                 tag_match;
   logic                                 table_write;
   logic                                 out_free;

   assign page_idx    = page_ff[vat_pkg::PAGE_W-1:0];
   // single tag comparator, stepped over the TLB by scan_ff
   assign tag_match   = tlb_valid_ff[scan_ff] && (tlb_tag_ff[scan_ff] == page_idx);
   assign table_write = (state_ff == ST_LOOKUP) && !table_valid_ff[page_idx];
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_hit_total        = rsp_hit_total_ff;
   assign rsp_fault_total      = rsp_fault_total_ff;

   // page table frames: written on a fault, read every cycle at the current page
   always_ff @(posedge clock) begin
      if (table_write) begin
         table_frame_ff[page_idx] <= next_free_ff;
      end
      table_rd_ff <= table_frame_ff[page_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tlb_valid_ff   <= '0;
         table_valid_ff <= '0;
         next_free_ff   <= '0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // drop the taken result unless a new one is loaded this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  page_ff   <= req_logical_address[vat_pkg::ADDR_W-1:vat_pkg::OFFSET_W];
                  offset_ff <= req_logical_address[vat_pkg::OFFSET_W-1:0];
                  hit_ff    <= 1'b0;
                  fault_ff  <= 1'b0;
                  state_ff  <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               // bring the page into the table's range one subtraction at a time
               if ({1'b0, page_ff} >= PAGE_LIMIT) begin
                  page_ff <= page_ff - PAGE_STEP;
               end else begin
                  scan_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tag_match) begin
                  hit_ff   <= 1'b1;
                  frame_ff <= tlb_frame_ff[scan_ff];
                  if (hit_count_ff != '1) begin
                     hit_count_ff <= hit_count_ff + 1'b1;
                  end
                  state_ff <= ST_FINISH;
               end else if (scan_ff == TLB_LAST) begin
                  state_ff <= ST_LOOKUP;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_LOOKUP: begin
               logic [vat_pkg::FRAME_W-1:0] new_frame;
               if (table_valid_ff[page_idx]) begin
                  new_frame = table_rd_ff;
               end else begin
                  new_frame = next_free_ff;
                  fault_ff  <= 1'b1;
                  table_valid_ff[page_idx] <= 1'b1;
                  next_free_ff <= (next_free_ff == FRAME_LAST) ? '0 : next_free_ff + 1'b1;
                  if (fault_count_ff != '1) begin
                     fault_count_ff <= fault_count_ff + 1'b1;
                  end
               end
               frame_ff <= new_frame;
               // FIFO refill: shift toward entry 0, insert at the tail
               for (int i = 0; i < vat_pkg::TLB_ENTRIES - 1; i++) begin
                  tlb_tag_ff[i]   <= tlb_tag_ff[i+1];
                  tlb_frame_ff[i] <= tlb_frame_ff[i+1];
                  tlb_valid_ff[i] <= tlb_valid_ff[i+1];
               end
               tlb_tag_ff[vat_pkg::TLB_ENTRIES-1]   <= page_idx;
               tlb_frame_ff[vat_pkg::TLB_ENTRIES-1] <= new_frame;
               tlb_valid_ff[vat_pkg::TLB_ENTRIES-1] <= 1'b1;
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_addr_ff        <= {vat_pkg::OFFSET_W'(frame_ff), offset_ff};
                  rsp_hit_ff         <= hit_ff;
                  rsp_fault_ff       <= fault_ff;
                  rsp_hit_total_ff   <= hit_count_ff;
                  rsp_fault_total_ff <= fault_count_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_hit_fault_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_fault_ff))
      else $error("hit and fault reported together");

   a_totals_track_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((!rsp_hit_ff || rsp_hit_total_ff != '0) &&
                        (!rsp_fault_ff || rsp_fault_total_ff != '0)))
      else $error("flag set with a zero running total");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_addr_ff)))
      else $error("stalled result lost or changed");

   a_fault_only_after_miss: assert property (@(posedge clock) disable iff (reset)
      table_write |-> !hit_ff)
      else $error("page table written after a TLB hit");
`endif

endmodule

FILE: tb/vat_checker.sv
// Scoreboard for the address translator: predicts each result and compares it.
module vat_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [vat_pkg::ADDR_W-1:0]  req_logical_address,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [vat_pkg::ADDR_W-1:0]  rsp_physical_address,
   input  logic                        rsp_tlb_hit,
   input  logic                        rsp_page_fault,
   input  logic [vat_pkg::COUNT_W-1:0] rsp_hit_total,
   input  logic [vat_pkg::COUNT_W-1:0] rsp_fault_total,
   output int                          mismatches,
   output int                          pending,
   output int                          results_seen,
   output int                          hits_seen,
   output int                          faults_seen
);

   typedef struct packed {
      logic [vat_pkg::ADDR_W-1:0]  physical_address;
      logic                        tlb_hit;
      logic                        page_fault;
      logic [vat_pkg::COUNT_W-1:0] hit_total;
      logic [vat_pkg::COUNT_W-1:0] fault_total;
   } translation_type;

   translation_type translation_q[$];

   logic [7:0]                  tlb_tag   [vat_pkg::TLB_ENTRIES];
   logic [7:0]                  tlb_frame [vat_pkg::TLB_ENTRIES];
   logic                        tlb_live  [vat_pkg::TLB_ENTRIES];
   logic [7:0]                  page_frame  [vat_pkg::PAGE_COUNT];
   logic                        page_mapped [vat_pkg::PAGE_COUNT];
   logic [8:0]                  free_frame;
   logic [vat_pkg::COUNT_W-1:0] hit_count;
   logic [vat_pkg::COUNT_W-1:0] fault_count;

   // Look up one address, update the TLB, page table and totals, return its result.
   function automatic translation_type translate(logic [vat_pkg::ADDR_W-1:0] addr);
      int unsigned     page;
      logic [7:0]      frame;
      logic            hit;
      logic            fault;
      translation_type res;
      page  = int'(addr[15:8]) % vat_pkg::PAGE_COUNT;
      frame = '0;
      hit   = 1'b0;
      fault = 1'b0;
      // lowest matching valid entry wins
      for (int i = 0; i < vat_pkg::TLB_ENTRIES; i++) begin
         if (!hit && tlb_live[i] && tlb_tag[i] == page[7:0]) begin
            hit   = 1'b1;
            frame = tlb_frame[i];
         end
      end
      if (hit) begin
         if (hit_count != '1) hit_count = hit_count + 1'b1;
      end else begin
         if (!page_mapped[page]) begin
            fault             = 1'b1;
            page_frame[page]  = free_frame[7:0];
            page_mapped[page] = 1'b1;
            free_frame        = free_frame + 1'b1;
            if (free_frame >= vat_pkg::FRAME_COUNT) free_frame = '0;
            if (fault_count != '1) fault_count = fault_count + 1'b1;
         end
         frame = page_frame[page];
         // shift toward entry 0 and insert at the tail
         for (int i = 0; i < vat_pkg::TLB_ENTRIES - 1; i++) begin
            tlb_tag[i]   = tlb_tag[i + 1];
            tlb_frame[i] = tlb_frame[i + 1];
            tlb_live[i]  = tlb_live[i + 1];
         end
         tlb_tag[vat_pkg::TLB_ENTRIES - 1]   = page[7:0];
         tlb_frame[vat_pkg::TLB_ENTRIES - 1] = frame;
         tlb_live[vat_pkg::TLB_ENTRIES - 1]  = 1'b1;
      end
      res.physical_address = {frame, addr[7:0]};
      res.tlb_hit          = hit;
      res.page_fault       = fault;
      res.hit_total        = hit_count;
      res.fault_total      = fault_count;
      return res;
   endfunction

   task automatic compare_field(string name, logic [vat_pkg::COUNT_W-1:0] want,
                                logic [vat_pkg::COUNT_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
      end
   endtask

   initial begin
      mismatches   = 0;
      pending      = 0;
      results_seen = 0;
      hits_seen    = 0;
      faults_seen  = 0;
   end

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         translation_q.delete();
         for (int i = 0; i < vat_pkg::TLB_ENTRIES; i++) begin
            tlb_tag[i]   = '0;
            tlb_frame[i] = '0;
            tlb_live[i]  = 1'b0;
         end
         for (int p = 0; p < vat_pkg::PAGE_COUNT; p++) begin
            page_frame[p]  = '0;
            page_mapped[p] = 1'b0;
         end
         free_frame  = '0;
         hit_count   = '0;
         fault_count = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (translation_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing pending: %0h", results_seen,
                           rsp_physical_address);
            end else begin
               want = translation_q.pop_front();
               compare_field("physical_address",
                             vat_pkg::COUNT_W'(want.physical_address),
                             vat_pkg::COUNT_W'(rsp_physical_address));
               compare_field("tlb_hit", vat_pkg::COUNT_W'(want.tlb_hit),
                             vat_pkg::COUNT_W'(rsp_tlb_hit));
               compare_field("page_fault", vat_pkg::COUNT_W'(want.page_fault),
                             vat_pkg::COUNT_W'(rsp_page_fault));
               compare_field("hit_total", want.hit_total, rsp_hit_total);
               compare_field("fault_total", want.fault_total, rsp_fault_total);
            end
            results_seen++;
            if (rsp_tlb_hit === 1'b1) hits_seen++;
            if (rsp_page_fault === 1'b1) faults_seen++;
         end
         if (req_valid && !req_stall)
            translation_q.push_back(translate(req_logical_address));
      end
      pending <= translation_q.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the translator testbench: clock, reset, address stimulus and the verdict.
module testbench;

   localparam int QUIET_LIMIT = 5000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [vat_pkg::ADDR_W-1:0]  req_logical_address;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [vat_pkg::ADDR_W-1:0]  rsp_physical_address;
   logic                        rsp_tlb_hit;
   logic                        rsp_page_fault;
   logic [vat_pkg::COUNT_W-1:0] rsp_hit_total;
   logic [vat_pkg::COUNT_W-1:0] rsp_fault_total;

   int mismatches, pending, results_seen, hits_seen, faults_seen;

   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_served;
   int   hold_left;
   int   quiet_cycles;
   int   items_sent = 0;
   logic [7:0] last_page = '0;
   logic [7:0] ws_base = '0;

   always #4 clock = ~clock;

   virtual_address_translator_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

   vat_checker scoreboard (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_logical_address  (req_logical_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total),
      .mismatches           (mismatches),
      .pending              (pending),
      .results_seen         (results_seen),
      .hits_seen            (hits_seen),
      .faults_seen          (faults_seen)
   );

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_left   <= 0;
         hold_served <= 1'b0;
      end else if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= 199;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results pending",
                     QUIET_LIMIT, pending);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic [vat_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_logical_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly a drifting working set a little larger than the TLB, some repeats, some anywhere.
   function automatic logic [vat_pkg::ADDR_W-1:0] next_address();
      logic [7:0] page;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) page = ws_base + 8'($urandom_range(0, 19));
      else if (pick <= 7) page = last_page;
      else page = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) ws_base = 8'($urandom_range(0, 255));
      last_page = page;
      return {page, 8'($urandom_range(0, 255))};
   endfunction

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_item(next_address());
   endtask

   initial begin
      logic [vat_pkg::ADDR_W-1:0] edge_addrs [6];
      edge_addrs = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA};
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_logical_address = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: page and offset extremes, a hit right after the fault that mapped it
      foreach (edge_addrs[k]) send_item(edge_addrs[k]);
      // fill the TLB with sixteen new pages, evicting page 0, then revisit mapped pages
      for (int p = 1; p <= 16; p++) send_item({8'(p), 8'($urandom_range(0, 255))});
      send_item(16'h0012);
      send_item(16'hFF34);
      drain();

      send_random(120);
      drain();

      // touch every page once so the free frame pointer wraps
      sender_idle_pct = 58;
      for (int p = 0; p < vat_pkg::PAGE_COUNT; p++)
         send_item({8'(p), 8'($urandom_range(0, 255))});
      drain();

      sender_idle_pct    = 0;
      receiver_stall_pct = 58;
      send_random(140);
      drain();

      // long receiver hold-off while the sender keeps offering items
      receiver_stall_pct = 0;
      hold_request <= 1'b1;
      send_random(30);
      drain();

      sender_idle_pct    = 24;
      receiver_stall_pct = 24;
      send_random(140);
      drain();

      repeat (40) @(posedge clock);
      $display("%0d addresses sent, %0d results checked: %0d TLB hits, %0d page faults",
               items_sent, results_seen, hits_seen, faults_seen);
      $display("covered address extremes, TLB eviction, frame pointer wrap and stall back-pressure");
      if (mismatches == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
